/* hdl/loo_pkg.sv */
// ----------------------------------------------------------------------------
// Local orientational order package
// Shared types, register map, command codes and state encoding.
// ----------------------------------------------------------------------------
package loo_pkg;

    localparam int MAX_PARTICLES_DEF = 1024;
    localparam int CNT_W  = 11;
    localparam int SLOT_W = 10;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [30:0] CUTOFF_RST = 31'd131072;
    localparam logic [15:0] THRESH_RST = 16'd13107;
    localparam logic [30:0] BOX_RST    = 31'd655360;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_EVAL   = 2'd1,
        CMD_REPORT = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_CUTOFF = 3'd0,
        REG_THRESH = 3'd1,
        REG_BOX_X  = 3'd2,
        REG_BOX_Y  = 3'd3,
        REG_BOX_Z  = 3'd4,
        REG_COUNT  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [30:0]        cutoff_radius;
        logic signed [15:0] crystal_threshold;
        logic [30:0]        box_length_x;
        logic [30:0]        box_length_y;
        logic [30:0]        box_length_z;
        logic [CNT_W-1:0]   particle_count;
    } cfg_t;

    typedef enum logic [4:0] {
        S_IDLE, S_A_RD, S_NA0, S_NA1, S_NA2, S_NA3, S_CUT, S_CHK,
        S_WRAP1, S_WRAP2, S_FILT, S_SQY, S_SQZ, S_DIST, S_DOTY, S_DOTZ,
        S_NB0, S_NB1, S_NB2, S_NB3, S_DEN, S_RAT0, S_RAT, S_ACC, S_DIV, S_FIN
    } state_t;

endpackage

/* hdl/loo_if.sv */
// ----------------------------------------------------------------------------
// Local orientational order channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface loo_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [9:0]         index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;

    modport source (output valid, cmd, index, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, cmd, index, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface loo_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         particle_slot;
    logic signed [15:0] order_value;
    logic [9:0]         neighbour_total;
    logic               is_crystal;
    logic [10:0]        crystal_tally;
    logic signed [15:0] average_order;

    modport source (output valid, particle_slot, order_value, neighbour_total, is_crystal,
                    crystal_tally, average_order, input ready);
    modport sink (input valid, particle_slot, order_value, neighbour_total, is_crystal,
                  crystal_tally, average_order, output ready);
endinterface

/* hdl/local_orientational_order_core.sv */
// ----------------------------------------------------------------------------
// Local orientational order core
// Stores particles and computes the mean P2 order over periodic neighbours.
// ----------------------------------------------------------------------------
// Load writes one particle. Evaluate reads its slot, its squared norm and the squared cutoff,
// then per slot below the count skips its own slot, a slot out of range on an axis or past
// the cutoff, else scores a neighbour; then 32 divide steps (none without neighbours) and
// the word is posted. Report: 32 divide steps (none with a zero count), then the word.
// One word is in work at a time, on the shared multiplier and divide step.
// rst_n clears control state and totals asynchronously; particle memories start undefined.
module local_orientational_order_core
    import loo_pkg::*;
#(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    loo_in_if.sink            in_ch,
    loo_out_if.source         out_ch
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    cfg_t cfg;

    logic [95:0] pos_mem [MAX_PARTICLES];
    logic [47:0] dir_mem [MAX_PARTICLES];
    logic [95:0] rd_pos_reg;
    logic [47:0] rd_dir_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          in_range;
    logic          in_accept;
    logic          out_free;
    logic [CNT_W-1:0] n_act;

    state_t state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              slot_ok_reg, slot_ok_next;
    logic              eval_reg, eval_next;
    logic [95:0]       pa_reg, pa_next;
    logic [47:0]       va_reg, va_next;
    logic [31:0]       na_reg, na_next;
    logic [63:0]       cut2_reg, cut2_next;
    logic [CNT_W-1:0]  s_reg, s_next;
    logic [CNT_W-1:0]  found_reg, found_next;
    logic signed [34:0] d_reg [3];
    logic signed [34:0] d_next [3];
    logic [33:0]       a_reg [3];
    logic [33:0]       a_next [3];
    logic [63:0]       dist_reg, dist_next;
    logic signed [33:0] dot_reg, dot_next;
    logic [31:0]       nb_reg, nb_next;
    logic [63:0]       dot2_reg, dot2_next;
    logic [63:0]       den_reg, den_next;
    logic [63:0]       rem_reg, rem_next;
    logic [13:0]       q_reg, q_next;
    logic [14:0]       c2_reg, c2_next;
    logic [4:0]        step_reg, step_next;
    logic signed [31:0] sum_reg, sum_next;
    logic [11:0]       drem_reg, drem_next;
    logic [31:0]       dwork_reg, dwork_next;
    logic              dneg_reg, dneg_next;
    logic [11:0]       dden_reg, dden_next;
    logic signed [31:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovalid_reg, ovalid_next;
    logic [SLOT_W-1:0] oslot_reg, oslot_next;
    logic signed [15:0] oorder_reg, oorder_next;
    logic [9:0]        ototal_reg, ototal_next;
    logic              ocrys_reg, ocrys_next;
    logic [CNT_W-1:0]  otally_reg, otally_next;
    logic signed [15:0] oavg_reg, oavg_next;

    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;

    logic signed [31:0] pa_c [3];
    logic signed [31:0] pb_c [3];
    logic signed [15:0] va_c [3];
    logic signed [15:0] vb_c [3];
    logic signed [34:0] box_c [3];
    logic [63:0]       rat_diff;
    logic              rat_take;
    logic [12:0]       div_trial;
    logic [32:0]       q_mag;
    logic signed [32:0] q_sig;
    logic [32:0]       dot_abs;
    logic [16:0]       c2x3;
    logic signed [15:0] order_c;
    logic              crystal_c;
    logic signed [32:0] acc_sum;
    logic [63:0]       dist_sum;

    loo_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    loo_mul u_mul (
        .clk (clk),
        .a   (ma),
        .b   (mb),
        .p   (mp)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign in_range    = 32'(in_ch.index) < MAX_PARTICLES;
    assign wr_en       = in_accept && (in_ch.cmd == CMD_LOAD) && in_range;
    assign rd_addr     = (state_reg == S_IDLE) ? AW'(in_ch.index) : AW'(s_reg);
    assign n_act       = (32'(cfg.particle_count) < MAX_PARTICLES) ?
                         cfg.particle_count : CNT_W'(MAX_PARTICLES);
    assign out_free    = !ovalid_reg || out_ch.ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[AW'(in_ch.index)] <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
            dir_mem[AW'(in_ch.index)] <= {in_ch.dir_z, in_ch.dir_y, in_ch.dir_x};
        end
        rd_pos_reg <= pos_mem[rd_addr];
        rd_dir_reg <= dir_mem[rd_addr];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa_c[i] = pa_reg[32*i +: 32];
            pb_c[i] = rd_pos_reg[32*i +: 32];
            va_c[i] = va_reg[16*i +: 16];
            vb_c[i] = rd_dir_reg[16*i +: 16];
        end
        box_c[0] = {4'b0, cfg.box_length_x};
        box_c[1] = {4'b0, cfg.box_length_y};
        box_c[2] = {4'b0, cfg.box_length_z};
    end

    assign rat_diff  = den_reg - rem_reg;
    assign rat_take  = rem_reg >= rat_diff;
    assign div_trial = {drem_reg, dwork_reg[31]};
    assign q_mag     = {1'b0, dwork_reg};
    assign q_sig     = dneg_reg ? (-signed'(q_mag) - ((drem_reg != '0) ? 33'sd1 : 33'sd0))
                                : signed'(q_mag);
    assign dot_abs   = dot_reg[33] ? 33'(-dot_reg) : 33'(dot_reg);
    assign c2x3      = {1'b0, c2_reg, 1'b0} + {2'b0, c2_reg};
    assign order_c   = q_sig[15:0];
    assign crystal_c = order_c >= cfg.crystal_threshold;
    assign acc_sum   = {acc_reg[31], acc_reg} + 33'(order_c);
    assign dist_sum  = dist_reg + mp[63:0];

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        slot_ok_next = slot_ok_reg;
        eval_next   = eval_reg;
        pa_next     = pa_reg;
        va_next     = va_reg;
        na_next     = na_reg;
        cut2_next   = cut2_reg;
        s_next      = s_reg;
        found_next  = found_reg;
        d_next      = d_reg;
        a_next      = a_reg;
        dist_next   = dist_reg;
        dot_next    = dot_reg;
        nb_next     = nb_reg;
        dot2_next   = dot2_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        c2_next     = c2_reg;
        step_next   = step_reg;
        sum_next    = sum_reg;
        drem_next   = drem_reg;
        dwork_next  = dwork_reg;
        dneg_next   = dneg_reg;
        dden_next   = dden_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        oslot_next  = oslot_reg;
        oorder_next = oorder_reg;
        ototal_next = ototal_reg;
        ocrys_next  = ocrys_reg;
        otally_next = otally_reg;
        oavg_next   = oavg_reg;
        ma = '0;
        mb = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    case (in_ch.cmd)
                        CMD_EVAL:
                        begin
                            slot_next    = in_ch.index;
                            slot_ok_next = in_range;
                            eval_next    = 1'b1;
                            state_next   = S_A_RD;
                        end
                        CMD_REPORT:
                        begin
                            eval_next  = 1'b0;
                            dneg_next  = acc_reg[31];
                            dwork_next = (n_act == '0) ? '0 :
                                         (acc_reg[31] ? 32'(-acc_reg) : 32'(acc_reg));
                            drem_next  = '0;
                            dden_next  = {1'b0, n_act};
                            step_next  = '0;
                            state_next = (n_act == '0) ? S_FIN : S_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            S_A_RD:
            begin
                pa_next    = slot_ok_reg ? rd_pos_reg : '0;
                va_next    = slot_ok_reg ? rd_dir_reg : '0;
                state_next = S_NA0;
            end
            S_NA0:
            begin
                ma = 33'(va_c[0]);
                mb = 33'(va_c[0]);
                state_next = S_NA1;
            end
            S_NA1:
            begin
                na_next = mp[31:0];
                ma = 33'(va_c[1]);
                mb = 33'(va_c[1]);
                state_next = S_NA2;
            end
            S_NA2:
            begin
                na_next = na_reg + mp[31:0];
                ma = 33'(va_c[2]);
                mb = 33'(va_c[2]);
                state_next = S_NA3;
            end
            S_NA3:
            begin
                na_next = na_reg + mp[31:0];
                ma = {2'b0, cfg.cutoff_radius};
                mb = {2'b0, cfg.cutoff_radius};
                state_next = S_CUT;
            end
            S_CUT:
            begin
                cut2_next  = mp[63:0];
                s_next     = '0;
                found_next = '0;
                sum_next   = '0;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (s_reg >= n_act)
                begin
                    dneg_next  = sum_reg[31];
                    dwork_next = (found_reg == '0) ? '0 :
                                 (sum_reg[31] ? 32'(-sum_reg) : 32'(sum_reg));
                    drem_next  = '0;
                    dden_next  = {found_reg, 1'b0};
                    step_next  = '0;
                    state_next = (found_reg == '0) ? S_FIN : S_DIV;
                end
                else if (s_reg == {1'b0, slot_reg})
                begin
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    state_next = S_WRAP1;
                end
            end
            S_WRAP1:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_next[i] = 35'(pa_c[i]) - 35'(pb_c[i]);
                    if ((d_next[i] <<< 1) > box_c[i])
                    begin
                        d_next[i] = d_next[i] - box_c[i];
                    end
                end
                state_next = S_WRAP2;
            end
            S_WRAP2:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_next[i] = d_reg[i];
                    if ((d_reg[i] <<< 1) < -box_c[i])
                    begin
                        d_next[i] = d_reg[i] + box_c[i];
                    end
                    a_next[i] = d_next[i][34] ? 34'(-d_next[i]) : 34'(d_next[i]);
                end
                state_next = S_FILT;
            end
            S_FILT:
            begin
                ma = {1'b0, a_reg[0][31:0]};
                mb = {1'b0, a_reg[0][31:0]};
                if ((a_reg[0] > {3'b0, cfg.cutoff_radius}) ||
                    (a_reg[1] > {3'b0, cfg.cutoff_radius}) ||
                    (a_reg[2] > {3'b0, cfg.cutoff_radius}))
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = S_CHK;
                end
                else
                begin
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                dist_next = mp[63:0];
                ma = {1'b0, a_reg[1][31:0]};
                mb = {1'b0, a_reg[1][31:0]};
                state_next = S_SQZ;
            end
            S_SQZ:
            begin
                dist_next = dist_sum;
                ma = {1'b0, a_reg[2][31:0]};
                mb = {1'b0, a_reg[2][31:0]};
                state_next = S_DIST;
            end
            S_DIST:
            begin
                ma = 33'(va_c[0]);
                mb = 33'(vb_c[0]);
                if (dist_sum > cut2_reg)
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = S_CHK;
                end
                else
                begin
                    found_next = found_reg + 1'b1;
                    state_next = S_DOTY;
                end
            end
            S_DOTY:
            begin
                dot_next = mp[33:0];
                ma = 33'(va_c[1]);
                mb = 33'(vb_c[1]);
                state_next = S_DOTZ;
            end
            S_DOTZ:
            begin
                dot_next = dot_reg + mp[33:0];
                ma = 33'(va_c[2]);
                mb = 33'(vb_c[2]);
                state_next = S_NB0;
            end
            S_NB0:
            begin
                dot_next = dot_reg + mp[33:0];
                ma = 33'(vb_c[0]);
                mb = 33'(vb_c[0]);
                state_next = S_NB1;
            end
            S_NB1:
            begin
                nb_next = mp[31:0];
                ma = 33'(vb_c[1]);
                mb = 33'(vb_c[1]);
                state_next = S_NB2;
            end
            S_NB2:
            begin
                nb_next = nb_reg + mp[31:0];
                ma = 33'(vb_c[2]);
                mb = 33'(vb_c[2]);
                state_next = S_NB3;
            end
            S_NB3:
            begin
                nb_next = nb_reg + mp[31:0];
                ma = {1'b0, dot_abs[31:0]};
                mb = {1'b0, dot_abs[31:0]};
                state_next = S_DEN;
            end
            S_DEN:
            begin
                dot2_next = mp[63:0];
                ma = {1'b0, na_reg};
                mb = {1'b0, nb_reg};
                state_next = S_RAT0;
            end
            S_RAT0:
            begin
                den_next = mp[63:0];
                rem_next = dot2_reg;
                q_next   = '0;
                step_next = '0;
                if (mp[63:0] == '0)
                begin
                    c2_next    = '0;
                    state_next = S_ACC;
                end
                else if (dot2_reg >= mp[63:0])
                begin
                    c2_next    = 15'd16384;
                    state_next = S_ACC;
                end
                else
                begin
                    state_next = S_RAT;
                end
            end
            S_RAT:
            begin
                q_next    = {q_reg[12:0], rat_take};
                rem_next  = rat_take ? (rem_reg - rat_diff) : (rem_reg + rem_reg);
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd13)
                begin
                    c2_next    = {1'b0, q_next};
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                sum_next   = sum_reg + signed'(32'(c2x3)) - 32'sd16384;
                s_next     = s_reg + 1'b1;
                state_next = S_CHK;
            end
            S_DIV:
            begin
                if (div_trial >= {1'b0, dden_reg})
                begin
                    drem_next  = 12'(div_trial - {1'b0, dden_reg});
                    dwork_next = {dwork_reg[30:0], 1'b1};
                end
                else
                begin
                    drem_next  = div_trial[11:0];
                    dwork_next = {dwork_reg[30:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd31)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                    if (eval_reg)
                    begin
                        oslot_next  = slot_reg;
                        oorder_next = order_c;
                        ototal_next = found_reg[9:0];
                        ocrys_next  = crystal_c;
                        oavg_next   = '0;
                        if (crystal_c && (cnt_reg != '1))
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        otally_next = cnt_next;
                        if (acc_sum[32] != acc_sum[31])
                        begin
                            acc_next = acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        end
                        else
                        begin
                            acc_next = acc_sum[31:0];
                        end
                    end
                    else
                    begin
                        oslot_next  = '0;
                        oorder_next = '0;
                        ototal_next = '0;
                        ocrys_next  = 1'b0;
                        otally_next = cnt_reg;
                        if (q_sig > 33'sd16384)
                        begin
                            oavg_next = 16'sd16384;
                        end
                        else if (q_sig < -33'sd8192)
                        begin
                            oavg_next = -16'sd8192;
                        end
                        else
                        begin
                            oavg_next = q_sig[15:0];
                        end
                        acc_next = '0;
                        cnt_next = '0;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        slot_ok_reg <= slot_ok_next;
        eval_reg    <= eval_next;
        pa_reg      <= pa_next;
        va_reg      <= va_next;
        na_reg      <= na_next;
        cut2_reg    <= cut2_next;
        s_reg       <= s_next;
        found_reg   <= found_next;
        d_reg       <= d_next;
        a_reg       <= a_next;
        dist_reg    <= dist_next;
        dot_reg     <= dot_next;
        nb_reg      <= nb_next;
        dot2_reg    <= dot2_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        c2_reg      <= c2_next;
        step_reg    <= step_next;
        sum_reg     <= sum_next;
        drem_reg    <= drem_next;
        dwork_reg   <= dwork_next;
        dneg_reg    <= dneg_next;
        dden_reg    <= dden_next;
        oslot_reg   <= oslot_next;
        oorder_reg  <= oorder_next;
        ototal_reg  <= ototal_next;
        ocrys_reg   <= ocrys_next;
        otally_reg  <= otally_next;
        oavg_reg    <= oavg_next;
    end

    assign out_ch.valid           = ovalid_reg;
    assign out_ch.particle_slot   = oslot_reg;
    assign out_ch.order_value     = oorder_reg;
    assign out_ch.neighbour_total = ototal_reg;
    assign out_ch.is_crystal      = ocrys_reg;
    assign out_ch.crystal_tally   = otally_reg;
    assign out_ch.average_order   = oavg_reg;

endmodule

/* hdl/loo_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding cutoff, threshold, box and count.
// ----------------------------------------------------------------------------
module loo_cfg_regs
    import loo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cutoff_radius     <= CUTOFF_RST;
            cfg_reg.crystal_threshold <= THRESH_RST;
            cfg_reg.box_length_x      <= BOX_RST;
            cfg_reg.box_length_y      <= BOX_RST;
            cfg_reg.box_length_z      <= BOX_RST;
            cfg_reg.particle_count    <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_CUTOFF: cfg_reg.cutoff_radius     <= pwdata[30:0];
                REG_THRESH: cfg_reg.crystal_threshold <= pwdata[15:0];
                REG_BOX_X:  cfg_reg.box_length_x      <= pwdata[30:0];
                REG_BOX_Y:  cfg_reg.box_length_y      <= pwdata[30:0];
                REG_BOX_Z:  cfg_reg.box_length_z      <= pwdata[30:0];
                REG_COUNT:  cfg_reg.particle_count    <= pwdata[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_CUTOFF: prdata = {1'b0, cfg_reg.cutoff_radius};
            REG_THRESH: prdata = {{16{cfg_reg.crystal_threshold[15]}},
                                  cfg_reg.crystal_threshold};
            REG_BOX_X:  prdata = {1'b0, cfg_reg.box_length_x};
            REG_BOX_Y:  prdata = {1'b0, cfg_reg.box_length_y};
            REG_BOX_Z:  prdata = {1'b0, cfg_reg.box_length_z};
            REG_COUNT:  prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.particle_count};
            default:    prdata = '0;
        endcase
    end

endmodule

/* hdl/loo_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Registered 33 by 33 bit signed multiplier used for every product.
// ----------------------------------------------------------------------------
module loo_mul
    import loo_pkg::*;
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

/* hdl/loo_checker.sv */
// ----------------------------------------------------------------------------
// Local orientational order checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module loo_checker
    import loo_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  in_cmd,
    input logic        out_valid,
    input logic        out_ready,
    input logic [9:0]  particle_slot,
    input logic        is_crystal,
    input logic [10:0] crystal_tally,
    input logic [15:0] average_order
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_EVAL) |=> !in_ready)
        else $error("evaluate did not occupy the core");

    a_slot_avg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (particle_slot != '0) |-> (average_order == '0))
        else $error("evaluate word carries an average");

    a_tally: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_crystal |-> (crystal_tally != '0))
        else $error("crystal flagged with empty tally");

endmodule

bind local_orientational_order_core loo_checker u_loo_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_cmd        (in_ch.cmd),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .particle_slot (out_ch.particle_slot),
    .is_crystal    (out_ch.is_crystal),
    .crystal_tally (out_ch.crystal_tally),
    .average_order (out_ch.average_order)
);
